// ===== src/saq_pkg.sv =====
// Shared types and constants for the sorted alarm queue.
// No dependencies; saq_ctrl, saq_dp and the top level in src import this package.
package saq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RUN_W           = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_TICK  = 1'b1;
  localparam logic RK_FIRE   = 1'b0;
  localparam logic RK_REJECT = 1'b1;

  typedef struct packed {
    logic        command;
    logic [23:0] delay_seconds;
    logic [7:0]  message_tag;
  } saq_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] due_second;
    logic [7:0]  alarm_tag;
    logic        last_of_run;
  } saq_out_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  tag;
  } saq_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REJ,
    S_INS_RD0,
    S_INS_LOOP,
    S_INS_TAIL,
    S_POP_RD,
    S_POP_CHK,
    S_POP_LOOK,
    S_POP_EMIT
  } saq_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic ins_start;
    logic ins_step;
    logic ins_tail;
    logic rd_second;
    logic pend_latch;
    logic look_latch;
    logic emit_pop;
    logic emit_rej;
  } saq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic count_zero;
    logic ins_last;
    logic due;
    logic out_free;
    logic pend_last;
  } saq_stat_t;

endpackage

// ===== src/saq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module saq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/saq_ctrl.sv =====
// Sequencer for the sorted alarm queue: input handshake and table walk steps.
// Depends on saq_pkg (state enum, command and status structs).
module saq_ctrl import saq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  output logic      in_ready,
  input  saq_stat_t stat,
  output saq_cmd_t  cmd
);

  saq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // head reads (insert start, pop) use the default read offset of zero
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_command == CMD_TICK) begin
            state_nxt = S_POP_RD;
          end else if (stat.full) begin
            state_nxt = S_REJ;
          end else begin
            state_nxt = S_INS_RD0;
          end
        end
      end
      S_REJ: begin
        if (stat.out_free) begin
          cmd.emit_rej = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_INS_RD0: begin
        cmd.ins_start = 1'b1;
        state_nxt     = stat.count_zero ? S_INS_TAIL : S_INS_LOOP;
      end
      S_INS_LOOP: begin
        cmd.ins_step = 1'b1;
        if (stat.ins_last) begin
          state_nxt = S_INS_TAIL;
        end
      end
      S_INS_TAIL: begin
        cmd.ins_tail = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_POP_RD: begin
        if (stat.count_zero) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        if (stat.due) begin
          cmd.pend_latch = 1'b1;
          cmd.rd_second  = 1'b1;
          state_nxt      = S_POP_LOOK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POP_LOOK: begin
        cmd.look_latch = 1'b1;
        state_nxt      = S_POP_EMIT;
      end
      S_POP_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_pop = 1'b1;
          state_nxt    = stat.pend_last ? S_IDLE : S_POP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/saq_dp.sv =====
// Datapath of the sorted alarm queue: second counter, circular table in RAM,
// insert ripple, pop lookahead and output register. Depends on saq_pkg, saq_ram.
module saq_dp import saq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  saq_in_t   in_item,
  input  logic      out_ready,
  output logic      out_valid,
  output saq_out_t  out_item,
  input  saq_cmd_t  cmd,
  output saq_stat_t stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [31:0]        now_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic               placed_r;
  saq_entry_t         hold_r;
  saq_entry_t         pend_r;
  logic               pend_last_r;
  logic [RUN_W-1:0]   run_r;
  logic [23:0]        delay_r;
  logic [7:0]         tag_r;
  logic               out_valid_r;
  saq_out_t           out_item_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  saq_entry_t         ram_wdata;
  saq_entry_t         ram_rdata;
  logic [CW-1:0]      rd_off;
  logic [CW-1:0]      wr_off;
  saq_entry_t         new_entry;
  logic [31:0]        rd_key;
  logic               rd_later;
  logic               rd_due;
  logic               out_free;

  // head plus offset, wrapped into the table
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign new_entry.deadline = now_r + {8'd0, delay_r};
  assign new_entry.tag      = tag_r;
  assign rd_key             = ram_rdata.deadline - now_r;
  assign rd_later           = rd_key > {8'd0, delay_r};
  assign rd_due             = ~(now_r - ram_rdata.deadline) >> 31 == 32'd1;
  assign out_free           = !out_valid_r || out_ready;

  always_comb begin
    rd_off = '0;
    if (cmd.rd_second) begin
      rd_off = CW'(1);
    end else if (cmd.ins_step) begin
      rd_off = idx_r + CW'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = new_entry;
    wr_off    = idx_r;
    if (cmd.ins_step) begin
      if (placed_r) begin
        ram_we    = 1'b1;
        ram_wdata = hold_r;
      end else if (rd_later) begin
        ram_we    = 1'b1;
        ram_wdata = new_entry;
      end
    end else if (cmd.ins_tail) begin
      ram_we    = 1'b1;
      wr_off    = count_r;
      ram_wdata = placed_r ? hold_r : new_entry;
    end
  end

  assign ram_raddr = slot(head_r, rd_off);
  assign ram_waddr = slot(head_r, wr_off);

  saq_ram #(
    .WIDTH ($bits(saq_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in && in_item.command == CMD_TICK) begin
        now_r <= now_r + 32'd1;
      end
      if (cmd.ins_tail) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.emit_pop) begin
        count_r <= count_r - CW'(1);
        head_r  <= slot(head_r, CW'(1));
      end
      if (cmd.emit_pop || cmd.emit_rej) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      delay_r <= in_item.delay_seconds;
      tag_r   <= in_item.message_tag;
      run_r   <= '0;
    end
    if (cmd.ins_start) begin
      idx_r    <= '0;
      placed_r <= 1'b0;
    end else if (cmd.ins_step) begin
      idx_r <= idx_r + CW'(1);
      if (placed_r || rd_later) begin
        hold_r   <= ram_rdata;
        placed_r <= 1'b1;
      end
    end
    if (cmd.pend_latch) begin
      pend_r <= ram_rdata;
    end
    if (cmd.look_latch) begin
      pend_last_r <= (run_r == RUN_W'(MAX_RESULTS - 1)) || (count_r == CW'(1)) || !rd_due;
    end
    if (cmd.emit_pop) begin
      run_r                  <= run_r + RUN_W'(1);
      out_item_r.result_kind <= RK_FIRE;
      out_item_r.due_second  <= pend_r.deadline;
      out_item_r.alarm_tag   <= pend_r.tag;
      out_item_r.last_of_run <= pend_last_r;
    end else if (cmd.emit_rej) begin
      out_item_r.result_kind <= RK_REJECT;
      out_item_r.due_second  <= new_entry.deadline;
      out_item_r.alarm_tag   <= tag_r;
      out_item_r.last_of_run <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;
  assign stat.full       = count_r == CW'(QUEUE_DEPTH);
  assign stat.count_zero = count_r == '0;
  assign stat.ins_last   = (idx_r + CW'(1)) == count_r;
  assign stat.due        = rd_due;
  assign stat.out_free   = out_free;
  assign stat.pend_last  = pend_last_r;

endmodule

// ===== src/sorted_alarm_queue.sv =====
// Sorted alarm queue, top level: joins the sequencer and the datapath.
// Depends on saq_pkg, saq_ctrl, saq_dp (which holds saq_ram).
//
// Usage:
//   in_*  : one item per handshake. command 0 adds an alarm that fires
//           delay_seconds after the current second; command 1 is a tick.
//   out_* : results. An add to a full table gives one reject item; a tick
//           gives one item per due alarm, earliest first, equal deadlines
//           in arrival order, at most 16 per tick, last_of_run on the final.
//           A successful add and a tick with nothing due give nothing.
// Timing: one item at a time. The table lives in a RAM with one write and
//   one registered read port; the insert ripple walks one entry per cycle.
//   add, room left : read the head, insert ripple over the table, write the tail
//   add, full      : emit the reject item once the output register is free
//   tick           : read the head and stop on an empty table or when the
//                    head is not due; for each fired alarm: read head,
//                    check, look at the next entry, emit
//   in_ready rises again as soon as the walk finishes, even while the last
//   result still sits in the output register.
// Stall: a held-off result stays in the output register; the walk waits on
//   it and input stays blocked until the walk ends.
// Reset (rst_n low, synchronous): second count zero, table empty, no result
//   pending. The RAM contents are not cleared; no unwritten entry's value is used.
module sorted_alarm_queue import saq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  saq_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output saq_out_t out_item
);

  saq_cmd_t  cmd;
  saq_stat_t stat;

  saq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_item.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  saq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

  // one item at a time: input is never accepted on consecutive cycles
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a reject is always the only result of its item
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind == RK_REJECT |-> out_item.last_of_run)
    else $error("reject result without last_of_run");

  // a reject is only ever issued against a full table
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rej |-> stat.full)
    else $error("reject issued while table has room");

endmodule
